// ===== hdl/assert_macros.svh =====
// Assertion helpers for the sliding window sender control RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that cond holds at every clock edge outside reset
`define SWSC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// check that ante in one cycle implies cons in the same cycle
`define SWSC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// check that ante in one cycle implies cons in the next cycle
`define SWSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/swsc_pkg.sv =====
// Shared types, widths, codes and reset values for the sliding window sender control.
// Used by swsc_update and sliding_window_sender_control_unit; depends on nothing.
`default_nettype none

package swsc_pkg;

    localparam int SEQ_W       = 10;
    localparam int CONN_W      = 3;
    localparam int MODE_W      = 2;
    localparam int TIME_W      = 32;
    localparam int WIN_W       = 8;
    localparam int TICK_W      = 16;
    localparam int LIM_W       = 4;
    localparam int DUP_W       = 2;
    localparam int STATUS_W    = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int DEF_MAX_CONNECTIONS = 8;

    localparam logic [WIN_W-1:0]  RST_WINDOW_SIZE  = 8'd64;
    localparam logic [SEQ_W-1:0]  RST_PACKETS      = 10'd512;
    localparam logic [TICK_W-1:0] RST_TIMEOUT      = 16'd100;
    localparam logic [LIM_W-1:0]  RST_GIVE_UP      = 4'd5;
    localparam logic [DUP_W-1:0]  RST_DUP_THRESH   = 2'd3;
    localparam logic [DUP_W-1:0]  DUP_SATURATE     = 2'd3;

    localparam logic [MODE_W-1:0] MODE_OPEN    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACK     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TIMEOUT = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_SIZE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PACKETS       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_GIVE_UP_LIMIT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DUP_THRESHOLD = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_NONE    = 3'd0,
        ST_OK      = 3'd1,
        ST_DONE    = 3'd2,
        ST_GAVEUP  = 3'd3,
        ST_IGNORED = 3'd4
    } status_t;

    typedef struct packed {
        logic [WIN_W-1:0]  window_size;
        logic [SEQ_W-1:0]  packets_per_chunk;
        logic [TICK_W-1:0] timeout_ticks;
        logic [LIM_W-1:0]  give_up_limit;
        logic [DUP_W-1:0]  dup_ack_threshold;
    } cfg_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CONN_W-1:0] conn;
        logic [SEQ_W-1:0]  ack_num;
        logic [TIME_W-1:0] now;
    } item_t;

    typedef struct packed {
        logic [SEQ_W-1:0]  acked_seq;
        logic [DUP_W-1:0]  dup_count;
        logic [LIM_W-1:0]  timeout_count;
        logic [SEQ_W-1:0]  next_to_send;
        logic [TIME_W-1:0] last_heard;
    } entry_t;

    typedef struct packed {
        logic              send_valid;
        logic [SEQ_W-1:0]  send_first;
        logic [SEQ_W-1:0]  send_last;
        status_t           status;
    } result_t;

    typedef struct packed {
        logic write;
        logic set_active;
        logic clr_active;
    } entry_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/sliding_window_sender_control_unit.sv =====
// Go-back-N sender control with fast retransmit over a table of connections.
// Top level; depends on swsc_pkg, swsc_update and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one word per item: mode (open,
//   ack, timeout check), conn, ack_num and now. Output channel
//   (out_valid/out_stall) returns exactly one result word per item: conn_out,
//   send_valid, send_first..send_last and status.
//   The entry memory is read at the accepting edge; the update, write-back
//   and output register load happen at the edge on which the update stage
//   advances, and that load raises out_valid.
//   Throughput is one item per cycle; a write-back to the entry that the next
//   item reads is forwarded, so back-to-back items on one conn need no gap.
//   When out_stall is high and the output register is full, the update stage
//   holds, with in_stall high while it holds a word, until the result is taken.
//   Configuration is a plain write port (cfg_write, cfg_index, cfg_data),
//   taken in the same cycle; the user must write it only while no items are
//   in flight; the block does not enforce it. Reset loads the default
//   configuration, clears all entry active bits, empties the pipeline; the
//   entry memory is not cleared: an entry is used only after an open wrote it.
`default_nettype none

module sliding_window_sender_control_unit #(
    parameter int MAX_CONNECTIONS = swsc_pkg::DEF_MAX_CONNECTIONS
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_write,
    input  logic [swsc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [swsc_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [swsc_pkg::MODE_W-1:0]     mode,
    input  logic [swsc_pkg::CONN_W-1:0]     conn,
    input  logic [swsc_pkg::SEQ_W-1:0]      ack_num,
    input  logic [swsc_pkg::TIME_W-1:0]     now,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [swsc_pkg::CONN_W-1:0]     conn_out,
    output logic                            send_valid,
    output logic [swsc_pkg::SEQ_W-1:0]      send_first,
    output logic [swsc_pkg::SEQ_W-1:0]      send_last,
    output logic [swsc_pkg::STATUS_W-1:0]   status
);

    localparam int AW    = (MAX_CONNECTIONS > 1) ? $clog2(MAX_CONNECTIONS) : 1;
    localparam int DEPTH = 1 << AW;
    localparam int XW    = (AW > swsc_pkg::CONN_W) ? AW : swsc_pkg::CONN_W;

    swsc_pkg::cfg_t       cfg_reg;
    swsc_pkg::entry_t     mem [DEPTH];
    logic [DEPTH-1:0]     active_reg;

    logic                 s1_valid_reg;
    swsc_pkg::item_t      s1_item_reg;
    swsc_pkg::entry_t     rd_entry_reg;
    swsc_pkg::entry_t     fwd_entry_reg;
    logic                 fwd_sel_reg;

    logic                 out_valid_reg;
    swsc_pkg::result_t    out_res_reg;
    logic [swsc_pkg::CONN_W-1:0] out_conn_reg;

    logic                 accept;
    logic                 s1_adv;
    logic [XW-1:0]        in_conn_x;
    logic [XW-1:0]        s1_conn_x;
    logic [AW-1:0]        in_addr;
    logic [AW-1:0]        s1_addr;
    swsc_pkg::item_t      in_item;
    swsc_pkg::entry_t     s1_entry;
    swsc_pkg::entry_t     entry_next;
    swsc_pkg::result_t    result;
    swsc_pkg::entry_ctl_t ctl;

    assign in_item   = '{mode: mode, conn: conn, ack_num: ack_num, now: now};
    assign in_conn_x = XW'(conn);
    assign s1_conn_x = XW'(s1_item_reg.conn);
    assign in_addr   = in_conn_x[AW-1:0];
    assign s1_addr   = s1_conn_x[AW-1:0];

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign accept   = in_valid && !in_stall;
    assign s1_entry = fwd_sel_reg ? fwd_entry_reg : rd_entry_reg;

    swsc_update #(
        .MAX_CONNECTIONS(MAX_CONNECTIONS)
    ) u_update (
        .item       (s1_item_reg),
        .entry      (s1_entry),
        .active     (active_reg[s1_addr]),
        .cfg        (cfg_reg),
        .entry_next (entry_next),
        .result     (result),
        .ctl        (ctl)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_size       <= swsc_pkg::RST_WINDOW_SIZE;
            cfg_reg.packets_per_chunk <= swsc_pkg::RST_PACKETS;
            cfg_reg.timeout_ticks     <= swsc_pkg::RST_TIMEOUT;
            cfg_reg.give_up_limit     <= swsc_pkg::RST_GIVE_UP;
            cfg_reg.dup_ack_threshold <= swsc_pkg::RST_DUP_THRESH;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                swsc_pkg::CFG_WINDOW_SIZE:
                    cfg_reg.window_size <= cfg_data[swsc_pkg::WIN_W-1:0];
                swsc_pkg::CFG_PACKETS:
                    cfg_reg.packets_per_chunk <= cfg_data[swsc_pkg::SEQ_W-1:0];
                swsc_pkg::CFG_TIMEOUT_TICKS:
                    cfg_reg.timeout_ticks <= cfg_data[swsc_pkg::TICK_W-1:0];
                swsc_pkg::CFG_GIVE_UP_LIMIT:
                    cfg_reg.give_up_limit <= cfg_data[swsc_pkg::LIM_W-1:0];
                swsc_pkg::CFG_DUP_THRESHOLD:
                    cfg_reg.dup_ack_threshold <= cfg_data[swsc_pkg::DUP_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // entry memory: read at accept, write back on update-stage advance if ctl.write
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_entry_reg <= mem[in_addr];
        end
        if (s1_adv && ctl.write)
        begin
            mem[s1_addr] <= entry_next;
        end
    end

    // forward a write-back that lands in the same cycle as the next read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_entry_reg <= entry_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= '0;
            s1_valid_reg <= 1'b0;
            fwd_sel_reg  <= 1'b0;
        end
        else
        begin
            if (s1_adv && ctl.set_active)
            begin
                active_reg[s1_addr] <= 1'b1;
            end
            else if (s1_adv && ctl.clr_active)
            begin
                active_reg[s1_addr] <= 1'b0;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_sel_reg  <= s1_adv && ctl.write && (s1_addr == in_addr);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= in_item;
        end
        if (s1_adv)
        begin
            out_res_reg  <= result;
            out_conn_reg <= s1_item_reg.conn;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign conn_out   = out_conn_reg;
    assign send_valid = out_res_reg.send_valid;
    assign send_first = out_res_reg.send_first;
    assign send_last  = out_res_reg.send_last;
    assign status     = out_res_reg.status;

`include "assert_macros.svh"

    `SWSC_ASSERT_IMPL(a_send_range, out_valid && send_valid, send_first != '0 && send_first <= send_last, "send range empty or starts at zero")
    `SWSC_ASSERT_IMPL(a_send_status, out_valid && send_valid, status == swsc_pkg::ST_OK, "send issued with a status other than ok")
    `SWSC_ASSERT_IMPL(a_idle_range, out_valid && !send_valid, send_first == '0 && send_last == '0, "range not cleared without send")
    `SWSC_ASSERT_NEXT(a_stage_hold, s1_valid_reg && !s1_adv, s1_valid_reg && $stable(s1_item_reg), "update stage lost a held word")

endmodule

`default_nettype wire

// ===== hdl/swsc_update.sv =====
// Per-item entry update: open, ack and timeout handling plus the send step.
// Depends on swsc_pkg; combinational, used by sliding_window_sender_control_unit.
`default_nettype none

module swsc_update #(
    parameter int MAX_CONNECTIONS = swsc_pkg::DEF_MAX_CONNECTIONS
) (
    input  swsc_pkg::item_t    item,
    input  swsc_pkg::entry_t   entry,
    input  logic               active,
    input  swsc_pkg::cfg_t     cfg,
    output swsc_pkg::entry_t   entry_next,
    output swsc_pkg::result_t  result,
    output swsc_pkg::entry_ctl_t ctl
);

    localparam int SEQ_W = swsc_pkg::SEQ_W;

    logic                        conn_ok;
    logic                        do_send;
    logic [swsc_pkg::DUP_W-1:0]  dup_inc;
    logic [swsc_pkg::LIM_W:0]    tmo_cnt;
    logic [swsc_pkg::TIME_W-1:0] elapsed;
    logic [SEQ_W:0]              top;
    logic [SEQ_W-1:0]            win_end;

    assign conn_ok = int'(item.conn) < MAX_CONNECTIONS;
    assign dup_inc = (entry.dup_count == swsc_pkg::DUP_SATURATE) ? swsc_pkg::DUP_SATURATE
                     : entry.dup_count + 2'd1;
    assign tmo_cnt = {1'b0, entry.timeout_count} + 5'd1;
    assign elapsed = item.now - entry.last_heard;

    always_comb
    begin
        entry_next        = entry;
        ctl               = '0;
        do_send           = 1'b0;
        result.send_valid = 1'b0;
        result.send_first = '0;
        result.send_last  = '0;
        result.status     = swsc_pkg::ST_IGNORED;
        top               = '0;
        win_end           = '0;

        if (conn_ok)
        begin
            if (item.mode == swsc_pkg::MODE_OPEN)
            begin
                ctl.write                = 1'b1;
                ctl.set_active           = 1'b1;
                entry_next.acked_seq     = '0;
                entry_next.dup_count     = '0;
                entry_next.timeout_count = '0;
                entry_next.next_to_send  = SEQ_W'(1);
                entry_next.last_heard    = item.now;
                do_send                  = 1'b1;
                result.status            = swsc_pkg::ST_OK;
            end
            else if (item.mode == swsc_pkg::MODE_ACK || item.mode == swsc_pkg::MODE_TIMEOUT)
            begin
                if (!active)
                begin
                    result.status = swsc_pkg::ST_NONE;
                end
                else if (item.mode == swsc_pkg::MODE_ACK)
                begin
                    if (item.ack_num == cfg.packets_per_chunk)
                    begin
                        ctl.clr_active = 1'b1;
                        result.status  = swsc_pkg::ST_DONE;
                    end
                    else if (item.ack_num > entry.acked_seq)
                    begin
                        ctl.write                = 1'b1;
                        entry_next.acked_seq     = item.ack_num;
                        entry_next.dup_count     = '0;
                        entry_next.timeout_count = '0;
                        entry_next.last_heard    = item.now;
                        do_send                  = 1'b1;
                        result.status            = swsc_pkg::ST_OK;
                    end
                    else if (item.ack_num == entry.acked_seq)
                    begin
                        ctl.write                = 1'b1;
                        entry_next.timeout_count = '0;
                        entry_next.last_heard    = item.now;
                        if (dup_inc >= cfg.dup_ack_threshold)
                        begin
                            // fast retransmit from the first unacked packet
                            entry_next.dup_count    = '0;
                            entry_next.next_to_send = entry.acked_seq + SEQ_W'(1);
                            do_send                 = 1'b1;
                        end
                        else
                        begin
                            entry_next.dup_count = dup_inc;
                        end
                        result.status = swsc_pkg::ST_OK;
                    end
                end
                else
                begin
                    if (elapsed < {{(swsc_pkg::TIME_W-swsc_pkg::TICK_W){1'b0}},
                                   cfg.timeout_ticks})
                    begin
                        result.status = swsc_pkg::ST_OK;
                    end
                    else if (tmo_cnt > {1'b0, cfg.give_up_limit})
                    begin
                        ctl.clr_active = 1'b1;
                        result.status  = swsc_pkg::ST_GAVEUP;
                    end
                    else
                    begin
                        ctl.write                = 1'b1;
                        entry_next.timeout_count = tmo_cnt[swsc_pkg::LIM_W-1:0];
                        entry_next.last_heard    = item.now;
                        entry_next.dup_count     = '0;
                        entry_next.next_to_send  = entry.acked_seq + SEQ_W'(1);
                        do_send                  = 1'b1;
                        result.status            = swsc_pkg::ST_OK;
                    end
                end
            end
        end

        // send step: window clipped at the chunk end; zero means nothing left
        top = {1'b0, entry_next.acked_seq}
              + {{(SEQ_W+1-swsc_pkg::WIN_W){1'b0}}, cfg.window_size};
        win_end = (top <= {1'b0, cfg.packets_per_chunk}) ? top[SEQ_W-1:0]
                  : cfg.packets_per_chunk;
        if (do_send && entry_next.next_to_send != '0 && entry_next.next_to_send <= win_end)
        begin
            result.send_valid       = 1'b1;
            result.send_first       = entry_next.next_to_send;
            result.send_last        = win_end;
            entry_next.next_to_send = win_end + SEQ_W'(1);
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/sliding_window_sender_control_unit_tb.sv =====
// Self-checking bench for the sliding window sender control unit.
// Depends on swsc_pkg and the top level; drives words with random idling and
// compares every result word against an in-bench go-back-N predictor.

module sliding_window_sender_control_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CONNS = swsc_pkg::DEF_MAX_CONNECTIONS;
    localparam logic [swsc_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 60;
    localparam int SETTLE_CYCLES = 6;
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASE_WORDS = 90;

    typedef struct packed {
        logic [swsc_pkg::CONN_W-1:0] conn;
        swsc_pkg::result_t           res;
    } planned_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [swsc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [swsc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [swsc_pkg::MODE_W-1:0] mode = '0;
    logic [swsc_pkg::CONN_W-1:0] conn = '0;
    logic [swsc_pkg::SEQ_W-1:0] ack_num = '0;
    logic [swsc_pkg::TIME_W-1:0] now = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [swsc_pkg::CONN_W-1:0] conn_out;
    logic send_valid;
    logic [swsc_pkg::SEQ_W-1:0] send_first;
    logic [swsc_pkg::SEQ_W-1:0] send_last;
    logic [swsc_pkg::STATUS_W-1:0] status;

    sliding_window_sender_control_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .conn       (conn),
        .ack_num    (ack_num),
        .now        (now),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .conn_out   (conn_out),
        .send_valid (send_valid),
        .send_first (send_first),
        .send_last  (send_last),
        .status     (status)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    logic [swsc_pkg::WIN_W-1:0]  cfg_window  = swsc_pkg::RST_WINDOW_SIZE;
    logic [swsc_pkg::SEQ_W-1:0]  cfg_packets = swsc_pkg::RST_PACKETS;
    logic [swsc_pkg::TICK_W-1:0] cfg_timeout = swsc_pkg::RST_TIMEOUT;
    logic [swsc_pkg::LIM_W-1:0]  cfg_give_up = swsc_pkg::RST_GIVE_UP;
    logic [swsc_pkg::DUP_W-1:0]  cfg_dup     = swsc_pkg::RST_DUP_THRESH;

    logic                        live     [CONNS] = '{default: 1'b0};
    logic [swsc_pkg::SEQ_W-1:0]  acked    [CONNS];
    logic [swsc_pkg::DUP_W-1:0]  dups     [CONNS];
    logic [swsc_pkg::LIM_W-1:0]  timeouts [CONNS];
    logic [swsc_pkg::SEQ_W-1:0]  next_pkt [CONNS];
    logic [swsc_pkg::TIME_W-1:0] heard    [CONNS];

    swsc_pkg::item_t item_backlog[$];
    planned_t        planned_results[$];

    int words_offered = 0;
    int words_taken = 0;
    int results_checked = 0;
    int mismatches = 0;
    int quiet_cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int settings_used = 1;

    logic [swsc_pkg::TIME_W-1:0] gen_clock;
    int gen_acked [CONNS];
    bit gen_open [CONNS];

    function automatic void window_send(input int c, inout swsc_pkg::result_t r);
        logic [swsc_pkg::SEQ_W:0]   top;
        logic [swsc_pkg::SEQ_W-1:0] wend;
        top = {1'b0, acked[c]} + cfg_window;
        wend = (top <= cfg_packets) ? top[swsc_pkg::SEQ_W-1:0] : cfg_packets;
        if (next_pkt[c] != '0 && next_pkt[c] <= wend)
        begin
            r.send_valid = 1'b1;
            r.send_first = next_pkt[c];
            r.send_last = wend;
            next_pkt[c] = wend + 1'b1;
        end
    endfunction

    function automatic void rewind_send(input int c, inout swsc_pkg::result_t r);
        next_pkt[c] = acked[c] + 1'b1;
        dups[c] = '0;
        window_send(c, r);
    endfunction

    function automatic planned_t plan_send(input swsc_pkg::item_t w);
        planned_t p;
        logic [swsc_pkg::LIM_W:0] tries;
        int c;
        c = w.conn;
        p.conn = w.conn;
        p.res.send_valid = 1'b0;
        p.res.send_first = '0;
        p.res.send_last = '0;
        p.res.status = swsc_pkg::ST_IGNORED;
        if (w.mode == swsc_pkg::MODE_OPEN)
        begin
            live[c] = 1'b1;
            acked[c] = '0;
            dups[c] = '0;
            timeouts[c] = '0;
            next_pkt[c] = {{(swsc_pkg::SEQ_W-1){1'b0}}, 1'b1};
            heard[c] = w.now;
            window_send(c, p.res);
            p.res.status = swsc_pkg::ST_OK;
        end
        else if (w.mode == swsc_pkg::MODE_ACK || w.mode == swsc_pkg::MODE_TIMEOUT)
        begin
            if (!live[c])
                p.res.status = swsc_pkg::ST_NONE;
            else if (w.mode == swsc_pkg::MODE_ACK)
            begin
                if (w.ack_num == cfg_packets)
                begin
                    live[c] = 1'b0;
                    p.res.status = swsc_pkg::ST_DONE;
                end
                else if (w.ack_num > acked[c])
                begin
                    acked[c] = w.ack_num;
                    dups[c] = '0;
                    timeouts[c] = '0;
                    heard[c] = w.now;
                    window_send(c, p.res);
                    p.res.status = swsc_pkg::ST_OK;
                end
                else if (w.ack_num == acked[c])
                begin
                    if (dups[c] < swsc_pkg::DUP_SATURATE)
                        dups[c] = dups[c] + 1'b1;
                    timeouts[c] = '0;
                    heard[c] = w.now;
                    if (dups[c] >= cfg_dup)
                        rewind_send(c, p.res);
                    p.res.status = swsc_pkg::ST_OK;
                end
            end
            else if (w.now - heard[c] < cfg_timeout)
                p.res.status = swsc_pkg::ST_OK;
            else
            begin
                tries = {1'b0, timeouts[c]} + 1'b1;
                if (tries > cfg_give_up)
                begin
                    live[c] = 1'b0;
                    p.res.status = swsc_pkg::ST_GAVEUP;
                end
                else
                begin
                    timeouts[c] = tries[swsc_pkg::LIM_W-1:0];
                    heard[c] = w.now;
                    rewind_send(c, p.res);
                    p.res.status = swsc_pkg::ST_OK;
                end
            end
        end
        return p;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t ns: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // sender: present the next word once the current one is taken
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || words_taken == words_offered))
        begin
            if (item_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin : load_word
                swsc_pkg::item_t w;
                w = item_backlog.pop_front();
                in_valid <= 1'b1;
                mode <= w.mode;
                conn <= w.conn;
                ack_num <= w.ack_num;
                now <= w.now;
                words_offered++;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: random stalls, plus a long hold on request
    always @(negedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin : monitor
        planned_t want;
        bit moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (planned_results.size() == 0)
                    report_mismatch("unexpected result word, conn_out", conn_out, -1);
                else
                begin
                    moved = 1'b1;
                    want = planned_results.pop_front();
                    results_checked++;
                    if (conn_out !== want.conn)
                        report_mismatch("conn_out", conn_out, want.conn);
                    if (send_valid !== want.res.send_valid)
                        report_mismatch("send_valid", send_valid, want.res.send_valid);
                    if (send_first !== want.res.send_first)
                        report_mismatch("send_first", send_first, want.res.send_first);
                    if (send_last !== want.res.send_last)
                        report_mismatch("send_last", send_last, want.res.send_last);
                    if (status !== want.res.status)
                        report_mismatch("status", status, want.res.status);
                end
            end
            if (in_valid && !in_stall)
            begin
                moved = 1'b1;
                planned_results.push_back(plan_send({mode, conn, ack_num, now}));
                words_taken++;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("sliding_window_sender_control_unit: mismatch");
        $finish;
    end

    task automatic push_word(input int m, input int c, input int a, input longint t);
        swsc_pkg::item_t w;
        w.mode = m[swsc_pkg::MODE_W-1:0];
        w.conn = c[swsc_pkg::CONN_W-1:0];
        w.ack_num = a[swsc_pkg::SEQ_W-1:0];
        w.now = t[swsc_pkg::TIME_W-1:0];
        item_backlog.push_back(w);
    endtask

    task automatic drain;
        while (item_backlog.size() != 0 || words_taken != words_offered
               || planned_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [swsc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [swsc_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            swsc_pkg::CFG_WINDOW_SIZE:   cfg_window = val[swsc_pkg::WIN_W-1:0];
            swsc_pkg::CFG_PACKETS:       cfg_packets = val[swsc_pkg::SEQ_W-1:0];
            swsc_pkg::CFG_TIMEOUT_TICKS: cfg_timeout = val[swsc_pkg::TICK_W-1:0];
            swsc_pkg::CFG_GIVE_UP_LIMIT: cfg_give_up = val[swsc_pkg::LIM_W-1:0];
            swsc_pkg::CFG_DUP_THRESHOLD: cfg_dup = val[swsc_pkg::DUP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input int win, input int pkts, input int ticks,
                                 input int limit, input int dup);
        write_reg(swsc_pkg::CFG_WINDOW_SIZE, win[swsc_pkg::CFG_DATA_W-1:0]);
        write_reg(swsc_pkg::CFG_PACKETS, pkts[swsc_pkg::CFG_DATA_W-1:0]);
        write_reg(swsc_pkg::CFG_TIMEOUT_TICKS, ticks[swsc_pkg::CFG_DATA_W-1:0]);
        write_reg(swsc_pkg::CFG_GIVE_UP_LIMIT, limit[swsc_pkg::CFG_DATA_W-1:0]);
        write_reg(swsc_pkg::CFG_DUP_THRESHOLD, dup[swsc_pkg::CFG_DATA_W-1:0]);
        @(negedge clk);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    task automatic queue_traffic(input int count);
        int k;
        int c;
        int pick;
        int a;
        int reps;
        for (k = 0; k < count; k++)
        begin
            gen_clock += $urandom_range(0, 20);
            c = $urandom_range(0, CONNS - 1);
            pick = $urandom_range(0, 99);
            if (pick < 10)
                push_word($urandom_range(0, 3), c, $urandom_range(0, 1023), $urandom);
            else if (!gen_open[c] || pick < 16)
            begin
                push_word(swsc_pkg::MODE_OPEN, c, $urandom_range(0, 1023), gen_clock);
                gen_open[c] = 1'b1;
                gen_acked[c] = 0;
            end
            else if (pick < 56)
            begin
                a = gen_acked[c] + $urandom_range(1, cfg_window + 1);
                if (a > cfg_packets && $urandom_range(0, 3) != 0)
                    a = cfg_packets;
                a = a % 1024;
                push_word(swsc_pkg::MODE_ACK, c, a, gen_clock);
                if (a == cfg_packets)
                    gen_open[c] = 1'b0;
                else if (a > gen_acked[c])
                    gen_acked[c] = a;
            end
            else if (pick < 78)
            begin
                reps = $urandom_range(1, 4);
                repeat (reps)
                begin
                    push_word(swsc_pkg::MODE_ACK, c, gen_acked[c], gen_clock);
                    gen_clock += $urandom_range(0, 5);
                end
            end
            else if (pick < 83)
                push_word(swsc_pkg::MODE_ACK, c, $urandom_range(0, gen_acked[c]), gen_clock);
            else
            begin
                if ($urandom_range(0, 2) != 0)
                    gen_clock += cfg_timeout + $urandom_range(0, 30);
                push_word(swsc_pkg::MODE_TIMEOUT, c, $urandom_range(0, 1023), gen_clock);
            end
        end
    endtask

    initial
    begin
        int p;
        send_idle_pct = 22;
        recv_idle_pct = 61;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        push_word(swsc_pkg::MODE_ACK, 0, 0, 0);
        push_word(swsc_pkg::MODE_TIMEOUT, 7, 0, 0);
        push_word(MODE_UNUSED, 5, 0, 0);
        push_word(swsc_pkg::MODE_OPEN, 0, 0, 0);
        push_word(swsc_pkg::MODE_ACK, 0, 10, 5);
        repeat (3) push_word(swsc_pkg::MODE_ACK, 0, 10, 6);
        push_word(swsc_pkg::MODE_ACK, 0, 5, 7);
        push_word(swsc_pkg::MODE_TIMEOUT, 0, 0, 50);
        for (p = 1; p <= 6; p++)
            push_word(swsc_pkg::MODE_TIMEOUT, 0, 0, 200 * p);
        push_word(swsc_pkg::MODE_OPEN, 7, 1023, 32'hFFFF_FFF0);
        push_word(swsc_pkg::MODE_ACK, 7, 1023, 32'hFFFF_FFF8);
        repeat (3) push_word(swsc_pkg::MODE_ACK, 7, 1023, 32'h0000_0005);
        push_word(swsc_pkg::MODE_TIMEOUT, 7, 0, 32'h0000_0010);
        push_word(swsc_pkg::MODE_ACK, 7, 512, 32'h0000_0020);
        push_word(swsc_pkg::MODE_OPEN, 3, 0, 32'h8000_0000);
        push_word(swsc_pkg::MODE_ACK, 3, 512, 32'h8000_0001);
        drain();

        gen_clock = $urandom;
        for (p = 0; p < 6; p++)
        begin
            case (p)
                0: apply_setting(255, 1023, 65535, 15, 3);
                1: apply_setting(1, 1, 1, 1, 1);
                default: apply_setting($urandom_range(1, 16), $urandom_range(8, 60),
                                       $urandom_range(5, 200), $urandom_range(1, 4),
                                       $urandom_range(1, 3));
            endcase
            send_idle_pct = (p < 2) ? 22 : (p < 4) ? 61 : 0;
            recv_idle_pct = (p < 2) ? 61 : (p < 4) ? 22 : 0;
            if (p == 0 || p == 4)
                hold_requests++;
            queue_traffic(PHASE_WORDS);
            drain();
        end

        if (planned_results.size() != 0)
            report_mismatch("results still outstanding", planned_results.size(), 0);
        $display("run covered %0d words in and %0d result words checked", words_taken,
                 results_checked);
        $display("across %0d register settings, with %0d field mismatches", settings_used,
                 mismatches);
        if (mismatches == 0)
            $display("sliding_window_sender_control_unit: match");
        else
            $display("sliding_window_sender_control_unit: mismatch");
        $finish;
    end

endmodule

// ===== sliding_window_sender_control_unit.f =====
+incdir+hdl
hdl/swsc_pkg.sv
hdl/swsc_update.sv
hdl/sliding_window_sender_control_unit.sv
tb/sv/sliding_window_sender_control_unit_tb.sv
